[rtl/core/scl_pkg.sv]
// Shared types and constants for the shell command lexer.
`timescale 1ns / 1ps
`default_nettype none

package scl_pkg;

    // Default longest word is one less than this value.
    localparam int MAX_WORD_DEF = 256;

    // Event bundles buffered between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // One byte can cause at most this many events.
    localparam int MAX_EVENTS = 4;

    localparam logic [3:0] K_CHAR   = 4'd0;
    localparam logic [3:0] K_WEND   = 4'd1;
    localparam logic [3:0] K_PIPE   = 4'd2;
    localparam logic [3:0] K_IN     = 4'd3;
    localparam logic [3:0] K_OUT    = 4'd4;
    localparam logic [3:0] K_APPEND = 4'd5;
    localparam logic [3:0] K_BG     = 4'd6;
    localparam logic [3:0] K_END    = 4'd7;
    localparam logic [3:0] K_ERRS   = 4'd8;
    localparam logic [3:0] K_ERRD   = 4'd9;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] char_value;
        logic       run_last;
    } t_out_item;

    // All events caused by one input byte, in emission order.
    typedef struct packed {
        logic [2:0]                  cnt;
        logic [MAX_EVENTS-1:0][3:0]  kind;
        logic [MAX_EVENTS-1:0][7:0]  chr;
    } t_bundle;

endpackage

`default_nettype wire

[rtl/core/scl_front.sv]
// Front end: lexer state and classification of each byte into an event bundle.
`timescale 1ns / 1ps
`default_nettype none

module scl_front #(
    parameter int MAX_WORD = scl_pkg::MAX_WORD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire scl_pkg::t_in_item i_item,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output scl_pkg::t_bundle       o_bundle
);
    import scl_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD - 1);

    localparam logic [2:0] M_NORMAL = 3'd0;
    localparam logic [2:0] M_SQ     = 3'd1;
    localparam logic [2:0] M_DQ     = 3'd2;
    localparam logic [2:0] M_DQE    = 3'd3;
    localparam logic [2:0] M_ESC    = 3'd4;
    localparam logic [2:0] M_DONE   = 3'd5;

    localparam logic [7:0] CH_PIPE = 8'h7C;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;

    logic [2:0]       r_mode, n_mode;
    logic             r_gt, n_gt;
    logic [LEN_W-1:0] r_len, n_len;
    logic             accept;
    logic             consumed;
    logic             add_ok;
    logic             is_space;
    logic [7:0]       b;
    logic             lst;
    t_bundle          bnd;

    function automatic t_bundle f_push(input t_bundle cur, input logic [3:0] k,
                                       input logic [7:0] c);
        t_bundle res;
        res = cur;
        if (cur.cnt < 3'(MAX_EVENTS)) begin
            res.kind[cur.cnt[1:0]] = k;
            res.chr[cur.cnt[1:0]]  = c;
            res.cnt                = cur.cnt + 3'd1;
        end
        return res;
    endfunction

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign b       = i_item.byte_req;
    assign lst     = i_item.last;
    assign add_ok  = (r_len != LEN_MAX);
    assign is_space = (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) ||
                      (b == CH_FF) || (b == CH_CR);

    always_comb begin
        n_mode   = r_mode;
        n_gt     = r_gt;
        n_len    = r_len;
        bnd      = '0;
        consumed = 1'b0;
        if (r_mode != M_DONE) begin
            // A pending '>' is resolved by the byte that follows it.
            if (r_gt) begin
                n_gt = 1'b0;
                if (b == CH_GT) begin
                    bnd      = f_push(bnd, K_APPEND, 8'd0);
                    consumed = 1'b1;
                end else begin
                    bnd = f_push(bnd, K_OUT, 8'd0);
                end
            end
            if (!consumed) begin
                unique case (r_mode)
                    M_SQ: begin
                        if (b == CH_SQ) begin
                            n_mode = M_NORMAL;
                        end else if (add_ok) begin
                            n_len = r_len + LEN_W'(1);
                            bnd   = f_push(bnd, K_CHAR, b);
                        end
                    end
                    M_DQ: begin
                        if (b == CH_DQ) begin
                            n_mode = M_NORMAL;
                        end else if (b == CH_BSL && !lst) begin
                            n_mode = M_DQE;
                        end else if (add_ok) begin
                            n_len = r_len + LEN_W'(1);
                            bnd   = f_push(bnd, K_CHAR, b);
                        end
                    end
                    M_DQE: begin
                        n_mode = M_DQ;
                        if (add_ok) begin
                            n_len = r_len + LEN_W'(1);
                            bnd   = f_push(bnd, K_CHAR, b);
                        end
                    end
                    M_ESC: begin
                        n_mode = M_NORMAL;
                        if (add_ok) begin
                            n_len = r_len + LEN_W'(1);
                            bnd   = f_push(bnd, K_CHAR, b);
                        end
                    end
                    default: begin
                        n_mode = M_NORMAL;
                        if (b == CH_NL || is_space || b == CH_PIPE || b == CH_LT ||
                            b == CH_GT || b == CH_AMP) begin
                            if (r_len != '0) begin
                                bnd   = f_push(bnd, K_WEND, 8'd0);
                                n_len = '0;
                            end
                        end
                        priority if (b == CH_NL) begin
                            bnd    = f_push(bnd, K_END, 8'd0);
                            n_mode = M_DONE;
                        end else if (is_space) begin
                        end else if (b == CH_PIPE) begin
                            bnd = f_push(bnd, K_PIPE, 8'd0);
                        end else if (b == CH_LT) begin
                            bnd = f_push(bnd, K_IN, 8'd0);
                        end else if (b == CH_GT) begin
                            n_gt = 1'b1;
                        end else if (b == CH_AMP) begin
                            bnd = f_push(bnd, K_BG, 8'd0);
                        end else if (b == CH_SQ) begin
                            n_mode = M_SQ;
                        end else if (b == CH_DQ) begin
                            n_mode = M_DQ;
                        end else if (b == CH_BSL && !lst) begin
                            n_mode = M_ESC;
                        end else if (add_ok) begin
                            n_len = r_len + LEN_W'(1);
                            bnd   = f_push(bnd, K_CHAR, b);
                        end
                    end
                endcase
            end
            // End of string: close an open quote with an error, else finish the line unless a newline already did.
            if (lst) begin
                priority if (n_mode == M_SQ) begin
                    bnd = f_push(bnd, K_ERRS, 8'd0);
                end else if (n_mode == M_DQ || n_mode == M_DQE) begin
                    bnd = f_push(bnd, K_ERRD, 8'd0);
                end else if (n_mode != M_DONE) begin
                    if (n_gt) begin
                        bnd = f_push(bnd, K_OUT, 8'd0);
                    end
                    if (n_len != '0) begin
                        bnd = f_push(bnd, K_WEND, 8'd0);
                    end
                    bnd = f_push(bnd, K_END, 8'd0);
                end else begin
                end
            end
        end
        if (lst) begin
            n_mode = M_NORMAL;
            n_gt   = 1'b0;
            n_len  = '0;
        end
    end

    assign o_push   = accept && (bnd.cnt != 3'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_gt   <= 1'b0;
            r_len  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_gt   <= n_gt;
            r_len  <= n_len;
        end
    end

endmodule

`default_nettype wire

[rtl/core/scl_queue.sv]
// Small FIFO of event bundles between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module scl_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire scl_pkg::t_bundle i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output scl_pkg::t_bundle      o_data
);
    import scl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_bundle          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PTR_W + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (PTR_W + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/scl_back.sv]
// Back end: takes bundles from the queue and sends their events one per cycle while i_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module scl_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire scl_pkg::t_bundle i_q_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output scl_pkg::t_out_item    o_item
);
    import scl_pkg::*;

    t_bundle    r_cur;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       fire;
    logic       last_ev;

    assign fire    = r_busy && !i_stall;
    assign last_ev = ({1'b0, r_idx} == (r_cur.cnt - 3'd1));
    assign o_pop   = i_q_valid && (!r_busy || (fire && last_ev));

    assign o_valid           = r_busy;
    assign o_item.kind       = r_cur.kind[r_idx];
    assign o_item.char_value = r_cur.chr[r_idx];
    assign o_item.run_last   = last_ev;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire) begin
            if (last_ev) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/shell_command_lexer.sv]
// Top level of the streaming shell command line lexer.
//
// Input channel: one command-line byte per transaction on i_item, with
// i_item.last set on the byte that ends the string. o_stall rises only when
// the internal queue of event bundles is full.
// Output channel: one token event per transaction on o_item (kind, character,
// run_last marks the final event caused by one input byte).
// Throughput: one input byte per cycle while o_stall is low. The back end
// sends one event per cycle while i_stall is low, so a byte that causes
// several events (up to four) holds the output until all are sent; a
// four-entry bundle queue absorbs such bursts, and bytes that cause no event
// are not queued. With the block idle, a byte's bundle is written into the
// queue when the byte is accepted and then loaded into the back end's bundle
// register, which drives o_item.
// Reset (synchronous, i_rst_n low) returns the lexer to its start state,
// empties the queue and drops o_valid. While i_stall is high the current
// event stays on o_item, the queue fills, and then o_stall holds off input.
`timescale 1ns / 1ps
`default_nettype none

module shell_command_lexer #(
    parameter int MAX_WORD = scl_pkg::MAX_WORD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire scl_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output scl_pkg::t_out_item     o_item
);
    import scl_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    t_bundle q_in;
    t_bundle q_out;

    scl_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_bundle (q_in)
    );

    scl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    scl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

`default_nettype wire

[rtl/core/scl_checker.sv]
// Port-level checks for the shell command lexer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module scl_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire scl_pkg::t_out_item o_item
);
    import scl_pkg::*;

    // A stalled output event must wait unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output event changed while stalled");

    // Only word characters carry a character value.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.kind != K_CHAR) |-> (o_item.char_value == 8'd0))
        else $error("non-character event carries a character value");

    // End and error events always close the events of their byte.
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.kind == K_END || o_item.kind == K_ERRS ||
                    o_item.kind == K_ERRD) |-> o_item.run_last)
        else $error("end or error event not marked final");

    // Kind codes beyond the error codes never appear.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.kind <= K_ERRD))
        else $error("undefined event kind");

    // Reset leaves no event pending on the output.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind shell_command_lexer scl_checker u_scl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

`default_nettype wire
